/* sv/aeps_pkg.sv */
// Shared types and constants for the active/expired priority scheduler.
// No dependencies; used by aeps_ctrl, aeps_dpath and the top level.
`default_nettype none

package aeps_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int PRIO_LEVELS_DEF = 16;

    localparam int FUNC_W = 2;
    localparam int ID_W   = 8;
    localparam int DYN_W  = 5;
    localparam int STAT_W = 5;
    localparam int PRIO_W = 4;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD     = 2'd0,
        FUNC_GET     = 2'd1,
        FUNC_PREEMPT = 2'd2,
        FUNC_NONE    = 2'd3
    } func_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
    } cmd_t;

endpackage

`default_nettype wire

/* sv/aeps_ctrl.sv */
// Controller state machine of the scheduler: accept, execute, respond.
// Depends on aeps_pkg for the command struct.
`default_nettype none

module aeps_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    output logic               done,
    output aeps_pkg::cmd_t     cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_RESP = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                state_next = start ? ST_EXEC : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // New beat may enter while the previous result is on the outputs.
    assign busy     = (state_reg == ST_EXEC);
    assign done     = (state_reg == ST_RESP);
    assign cmd.load = start && !busy;
    assign cmd.exec = (state_reg == ST_EXEC);

endmodule

`default_nettype wire

/* sv/aeps_dpath.sv */
// Datapath of the scheduler: per-priority FIFO buckets for both queues,
// bucket pointers, queue counts and result registers. Depends on aeps_pkg.
`default_nettype none

module aeps_dpath #(
    parameter int QUEUE_DEPTH = aeps_pkg::QUEUE_DEPTH_DEF,
    parameter int PRIO_LEVELS = aeps_pkg::PRIO_LEVELS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire aeps_pkg::cmd_t                    cmd,
    input  wire logic [aeps_pkg::FUNC_W-1:0]       func,
    input  wire logic [aeps_pkg::ID_W-1:0]         process_id,
    input  wire logic signed [aeps_pkg::DYN_W-1:0] dynamic_priority,
    input  wire logic [aeps_pkg::STAT_W-1:0]       static_priority,
    input  wire logic                              current_valid,
    input  wire logic [aeps_pkg::PRIO_W-1:0]       current_priority,
    output logic                                   result_valid,
    output logic [aeps_pkg::ID_W-1:0]              process_id_out,
    output logic [aeps_pkg::PRIO_W-1:0]            priority_out,
    output logic                                   preempt,
    output logic                                   dropped
);

    // Stored priorities are 4 bits, so at most 16 buckets are ever used.
    localparam int NB        = (PRIO_LEVELS > 16) ? 16 : PRIO_LEVELS;
    localparam int BW        = $clog2(NB);
    localparam int PW        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW        = $clog2(QUEUE_DEPTH + 1);
    localparam int AW        = 1 + BW + PW;
    localparam int MEM_DEPTH = 2 ** AW;
    localparam int IW        = aeps_pkg::ID_W;
    localparam int RW        = 7;

    localparam logic [PW-1:0]        PTR_LAST = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0]        CNT_FULL = CW'(QUEUE_DEPTH);
    localparam logic signed [RW-1:0] PRIO_MAX = RW'(PRIO_LEVELS - 1);
    localparam logic signed [aeps_pkg::DYN_W-1:0] DYN_EXHAUSTED = -5'sd1;

    // Latched input beat.
    aeps_pkg::func_t              func_reg;
    logic [IW-1:0]                id_reg;
    logic signed [aeps_pkg::DYN_W-1:0] dyn_reg;
    logic [aeps_pkg::STAT_W-1:0]  stat_reg;
    logic                         cur_valid_reg;
    logic [aeps_pkg::PRIO_W-1:0]  cur_prio_reg;

    // Queue state.
    logic                         active_reg, active_next;
    logic [CW-1:0]                count_reg [2];
    logic [CW-1:0]                count_next [2];
    logic [PW-1:0]                head_reg [2][NB];
    logic [PW-1:0]                head_next [2][NB];
    logic [PW-1:0]                tail_reg [2][NB];
    logic [PW-1:0]                tail_next [2][NB];
    logic [NB-1:0]                nonempty_reg [2];
    logic [NB-1:0]                nonempty_next [2];

    logic [IW-1:0]                mem [MEM_DEPTH];
    logic [IW-1:0]                mem_rd_reg;

    // Result registers.
    logic                         rv_reg, rv_next;
    logic [aeps_pkg::PRIO_W-1:0]  prio_out_reg, prio_out_next;
    logic                         preempt_reg, preempt_next;
    logic                         drop_reg, drop_next;
    logic                         pop_sel_reg, pop_sel_next;

    // Insert path.
    logic                         refill;
    logic signed [RW-1:0]         prio_raw;
    logic signed [RW-1:0]         prio_clamp;
    logic [aeps_pkg::PRIO_W-1:0]  ins_prio;
    logic [BW-1:0]                ins_bucket;
    logic                         ins_q;
    logic                         ins_full;
    logic [PW-1:0]                ins_tail;
    logic [PW-1:0]                ins_tail_inc;

    // Pop path.
    logic                         swap;
    logic                         pop_q;
    logic                         pop_ok;
    logic [BW-1:0]                pop_bucket;
    logic [PW-1:0]                pop_head;
    logic [PW-1:0]                pop_head_inc;

    logic                         mem_we;
    logic                         mem_re;
    logic [AW-1:0]                wr_addr;
    logic [AW-1:0]                rd_addr;
    logic signed [RW-1:0]         dyn_ext;

    assign dyn_ext  = RW'(dyn_reg);
    assign refill   = (dyn_reg == DYN_EXHAUSTED);
    assign prio_raw = refill ? ($signed({2'b00, stat_reg}) - 7'sd1) : dyn_ext;

    always_comb
    begin
        priority if (prio_raw < 7'sd0)
        begin
            prio_clamp = 7'sd0;
        end
        else if (prio_raw > PRIO_MAX)
        begin
            prio_clamp = PRIO_MAX;
        end
        else
        begin
            prio_clamp = prio_raw;
        end
    end

    assign ins_prio     = prio_clamp[aeps_pkg::PRIO_W-1:0];
    assign ins_bucket   = ins_prio[BW-1:0];
    assign ins_q        = refill ? ~active_reg : active_reg;
    assign ins_full     = (count_reg[ins_q] == CNT_FULL);
    assign ins_tail     = tail_reg[ins_q][ins_bucket];
    assign ins_tail_inc = (ins_tail == PTR_LAST) ? '0 : ins_tail + 1'b1;

    // Swap roles when the active queue ran dry and the expired one holds work.
    assign swap   = (count_reg[active_reg] == '0) && (count_reg[~active_reg] != '0);
    assign pop_q  = active_reg ^ swap;
    assign pop_ok = (count_reg[pop_q] != '0);

    // Highest nonempty bucket wins.
    always_comb
    begin
        pop_bucket = '0;
        for (int b = 0; b < NB; b++)
        begin
            if (nonempty_reg[pop_q][b])
            begin
                pop_bucket = BW'(b);
            end
        end
    end

    assign pop_head     = head_reg[pop_q][pop_bucket];
    assign pop_head_inc = (pop_head == PTR_LAST) ? '0 : pop_head + 1'b1;

    assign wr_addr = {ins_q, ins_bucket, ins_tail};
    assign rd_addr = {pop_q, pop_bucket, pop_head};
    assign mem_we  = cmd.exec && (func_reg == aeps_pkg::FUNC_ADD) && !ins_full;
    assign mem_re  = cmd.exec && (func_reg == aeps_pkg::FUNC_GET) && pop_ok;

    always_comb
    begin
        active_next   = active_reg;
        count_next    = count_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        nonempty_next = nonempty_reg;
        rv_next       = 1'b0;
        prio_out_next = '0;
        preempt_next  = 1'b0;
        drop_next     = 1'b0;
        pop_sel_next  = 1'b0;
        unique case (func_reg)
            aeps_pkg::FUNC_ADD:
            begin
                prio_out_next = ins_prio;
                if (ins_full)
                begin
                    drop_next = 1'b1;
                end
                else
                begin
                    rv_next                           = 1'b1;
                    tail_next[ins_q][ins_bucket]      = ins_tail_inc;
                    nonempty_next[ins_q][ins_bucket]  = 1'b1;
                    count_next[ins_q]                 = count_reg[ins_q] + 1'b1;
                end
            end
            aeps_pkg::FUNC_GET:
            begin
                active_next = pop_q;
                if (pop_ok)
                begin
                    rv_next                       = 1'b1;
                    pop_sel_next                  = 1'b1;
                    prio_out_next                 = aeps_pkg::PRIO_W'(pop_bucket);
                    head_next[pop_q][pop_bucket]  = pop_head_inc;
                    count_next[pop_q]             = count_reg[pop_q] - 1'b1;
                    // Pointers meet after a pop only when the bucket drains.
                    if (pop_head_inc == tail_reg[pop_q][pop_bucket])
                    begin
                        nonempty_next[pop_q][pop_bucket] = 1'b0;
                    end
                end
            end
            aeps_pkg::FUNC_PREEMPT:
            begin
                preempt_next = cur_valid_reg &&
                               (dyn_ext > $signed({3'b000, cur_prio_reg}));
            end
            aeps_pkg::FUNC_NONE:
            begin
                rv_next = 1'b0;
            end
            default:
            begin
                rv_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            for (int q = 0; q < 2; q++)
            begin
                count_reg[q]    <= '0;
                nonempty_reg[q] <= '0;
                for (int b = 0; b < NB; b++)
                begin
                    head_reg[q][b] <= '0;
                    tail_reg[q][b] <= '0;
                end
            end
        end
        else if (cmd.exec)
        begin
            active_reg   <= active_next;
            count_reg    <= count_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            nonempty_reg <= nonempty_next;
        end
    end

    // Payload registers: input beat and results.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg      <= aeps_pkg::func_t'(func);
            id_reg        <= process_id;
            dyn_reg       <= dynamic_priority;
            stat_reg      <= static_priority;
            cur_valid_reg <= current_valid;
            cur_prio_reg  <= current_priority;
        end
        if (cmd.exec)
        begin
            rv_reg       <= rv_next;
            prio_out_reg <= prio_out_next;
            preempt_reg  <= preempt_next;
            drop_reg     <= drop_next;
            pop_sel_reg  <= pop_sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= id_reg;
        end
        if (mem_re)
        begin
            mem_rd_reg <= mem[rd_addr];
        end
    end

    assign result_valid   = rv_reg;
    assign process_id_out = pop_sel_reg ? mem_rd_reg : id_reg;
    assign priority_out   = prio_out_reg;
    assign preempt        = preempt_reg;
    assign dropped        = drop_reg;

endmodule

`default_nettype wire

/* sv/active_expired_priority_scheduler_core.sv */
// Top level of the active/expired priority scheduler.
// Instantiates aeps_ctrl and aeps_dpath; depends on aeps_pkg.
//
// Usage:
//   Drive func and the operand ports and raise start. A beat is taken at a
//   rising edge where start is high and busy is low. Functions: add a
//   process, get the next process, test preemption.
//   Each beat produces exactly one result, shown for one cycle with done
//   high: result_valid, process_id_out, priority_out, preempt, dropped.
//   After the accepting edge the controller passes through the execute state
//   and then the respond state, in which done is high. A new beat is not
//   taken in the execute state (busy high); the next beat may be taken at the
//   edge that ends the done cycle. The beat is latched at the accepting edge,
//   the insert write or pop read happens in the execute cycle, and the
//   registered read data feeds the result cycle.
//   Queues are kept as per-priority FIFO buckets, so the highest-priority,
//   oldest entry is found by a priority encoder over the bucket flags.
//   Reset empties both queues and makes queue 0 active; no clearing pass.
//   The receiver cannot stall: results must be taken while done is high.
`default_nettype none

module active_expired_priority_scheduler_core #(
    parameter int QUEUE_DEPTH = aeps_pkg::QUEUE_DEPTH_DEF,
    parameter int PRIO_LEVELS = aeps_pkg::PRIO_LEVELS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [aeps_pkg::FUNC_W-1:0]       func,
    input  wire logic [aeps_pkg::ID_W-1:0]         process_id,
    input  wire logic signed [aeps_pkg::DYN_W-1:0] dynamic_priority,
    input  wire logic [aeps_pkg::STAT_W-1:0]       static_priority,
    input  wire logic                              current_valid,
    input  wire logic [aeps_pkg::PRIO_W-1:0]       current_priority,
    output logic                                   done,
    output logic                                   result_valid,
    output logic [aeps_pkg::ID_W-1:0]              process_id_out,
    output logic [aeps_pkg::PRIO_W-1:0]            priority_out,
    output logic                                   preempt,
    output logic                                   dropped
);

    aeps_pkg::cmd_t cmd;

    aeps_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    aeps_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PRIO_LEVELS (PRIO_LEVELS)
    ) u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .func             (func),
        .process_id       (process_id),
        .dynamic_priority (dynamic_priority),
        .static_priority  (static_priority),
        .current_valid    (current_valid),
        .current_priority (current_priority),
        .result_valid     (result_valid),
        .process_id_out   (process_id_out),
        .priority_out     (priority_out),
        .preempt          (preempt),
        .dropped          (dropped)
    );

endmodule

`default_nettype wire

/* test/tb.sv */
// Testbench for active_expired_priority_scheduler_core: a directed table, then random bursts.
// Every result is checked against a fixed table value or an in-bench model of the two priority queues.
// Depends on aeps_pkg and the core RTL.
`timescale 1ns / 100ps

module tb;

    localparam int Q_DEPTH     = aeps_pkg::QUEUE_DEPTH_DEF;
    localparam int PRIO_MAX    = aeps_pkg::PRIO_LEVELS_DEF - 1;
    localparam int ID_W        = aeps_pkg::ID_W;
    localparam int DYN_W       = aeps_pkg::DYN_W;
    localparam int STAT_W      = aeps_pkg::STAT_W;
    localparam int PRIO_W      = aeps_pkg::PRIO_W;
    localparam int ITEM_COUNT  = 550;
    localparam int DIR_ROWS    = 24;
    localparam int TAIL_CYCLES = 8;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        aeps_pkg::func_t         func;
        logic [ID_W-1:0]         pid;
        logic signed [DYN_W-1:0] dyn;
        logic [STAT_W-1:0]       stat;
        logic                    cv;
        logic [PRIO_W-1:0]       cp;
    } sched_cmd_t;

    typedef struct packed {
        logic               ok;
        logic [ID_W-1:0]    pid;
        logic [PRIO_W-1:0]  prio;
        logic               pre;
        logic               drop;
    } sched_res_t;

    typedef struct packed {
        sched_cmd_t cmd;
        logic       given;
        sched_res_t res;
    } dir_row_t;

    typedef struct packed {
        logic [ID_W-1:0]   pid;
        logic [PRIO_W-1:0] prio;
    } sched_ent_t;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    aeps_pkg::func_t func;
    logic [ID_W-1:0] process_id;
    logic signed [DYN_W-1:0] dynamic_priority;
    logic [STAT_W-1:0] static_priority;
    logic current_valid;
    logic [PRIO_W-1:0] current_priority;
    logic done;
    logic result_valid;
    logic [ID_W-1:0] process_id_out;
    logic [PRIO_W-1:0] priority_out;
    logic preempt;
    logic dropped;

    // model state: two sorted queues and the active selector
    sched_ent_t prio_q [2][$];
    logic       active_sel = 1'b0;

    sched_res_t pending_res_q[$];
    dir_row_t   stim_rows[DIR_ROWS];
    int         fail_count = 0;
    int         cycle_cnt = 0;
    sched_res_t got_res;
    sched_res_t want_res;

    active_expired_priority_scheduler_core DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .func             (func),
        .process_id       (process_id),
        .dynamic_priority (dynamic_priority),
        .static_priority  (static_priority),
        .current_valid    (current_valid),
        .current_priority (current_priority),
        .done             (done),
        .result_valid     (result_valid),
        .process_id_out   (process_id_out),
        .priority_out     (priority_out),
        .preempt          (preempt),
        .dropped          (dropped)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic sched_res_t predict_sched(input sched_cmd_t c);
        sched_res_t r;
        sched_ent_t ent;
        int p;
        int pos;
        int qi;
        begin
            r = '{ok: 1'b0, pid: c.pid, prio: '0, pre: 1'b0, drop: 1'b0};
            case (c.func)
                aeps_pkg::FUNC_ADD:
                begin
                    // exhausted quantum: refill from static and park in expired
                    if ($signed(c.dyn) == -5'sd1)
                    begin
                        p = int'(c.stat) - 1;
                        qi = int'(!active_sel);
                    end
                    else
                    begin
                        p = int'($signed(c.dyn));
                        qi = int'(active_sel);
                    end
                    if (p < 0)
                        p = 0;
                    if (p > PRIO_MAX)
                        p = PRIO_MAX;
                    r.prio = p[PRIO_W-1:0];
                    if (prio_q[qi].size() >= Q_DEPTH)
                        r.drop = 1'b1;
                    else
                    begin
                        // insert after every entry of equal or higher priority
                        pos = 0;
                        while (pos < prio_q[qi].size() && prio_q[qi][pos].prio >= r.prio)
                            pos++;
                        ent.pid = c.pid;
                        ent.prio = r.prio;
                        prio_q[qi].insert(pos, ent);
                        r.ok = 1'b1;
                    end
                end
                aeps_pkg::FUNC_GET:
                begin
                    if (prio_q[active_sel].size() == 0 && prio_q[!active_sel].size() != 0)
                        active_sel = !active_sel;
                    if (prio_q[active_sel].size() != 0)
                    begin
                        ent = prio_q[active_sel][0];
                        prio_q[active_sel].delete(0);
                        r.ok = 1'b1;
                        r.pid = ent.pid;
                        r.prio = ent.prio;
                    end
                end
                aeps_pkg::FUNC_PREEMPT:
                    r.pre = c.cv && (int'($signed(c.dyn)) > int'(c.cp));
                default:
                    ;
            endcase
            return r;
        end
    endfunction

    function automatic sched_cmd_t rand_cmd(input int add_pct, input int get_pct,
                                            input int exh_pct);
        sched_cmd_t c;
        int r;
        begin
            c.pid = ID_W'($urandom_range(0, 255));
            c.stat = STAT_W'($urandom_range(0, 31));
            c.cv = 1'($urandom_range(0, 1));
            c.cp = PRIO_W'($urandom_range(0, 15));
            c.dyn = DYN_W'($urandom_range(0, 31));
            r = $urandom_range(0, 99);
            if (r < add_pct)
                c.func = aeps_pkg::FUNC_ADD;
            else if (r < add_pct + get_pct)
                c.func = aeps_pkg::FUNC_GET;
            else if (r < 97)
                c.func = aeps_pkg::FUNC_PREEMPT;
            else
                c.func = aeps_pkg::FUNC_NONE;
            if (c.func == aeps_pkg::FUNC_ADD)
            begin
                if ($urandom_range(0, 99) < exh_pct)
                    c.dyn = -5'sd1;
                else if ($urandom_range(0, 4) != 0)
                    c.dyn = DYN_W'($urandom_range(0, 15));
            end
            return c;
        end
    endfunction

    function automatic int pick_gap(input bit no_idle);
        int r;
        begin
            if (no_idle)
                return 0;
            r = $urandom_range(0, 99);
            if (r < 65)
                return 0;
            if (r < 95)
                return $urandom_range(1, 3);
            return $urandom_range(10, 40);
        end
    endfunction

    // Present one beat, hold it until taken, then log its expected result.
    task automatic drive_beat(input sched_cmd_t c, input logic given,
                              input sched_res_t fixed_res);
        sched_res_t r;
        begin
            start <= 1'b1;
            func <= c.func;
            process_id <= c.pid;
            dynamic_priority <= c.dyn;
            static_priority <= c.stat;
            current_valid <= c.cv;
            current_priority <= c.cp;
            do
                @(posedge clk);
            while (busy);
            r = predict_sched(c);
            pending_res_q.insert(pending_res_q.size(), given ? fixed_res : r);
        end
    endtask

    task automatic idle_gap(input int n);
        begin
            if (n > 0)
            begin
                start <= 1'b0;
                repeat (n) @(posedge clk);
            end
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        begin
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                fail_count++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_res_q.size() == 0)
            begin
                $error("result beat with nothing pending: process_id_out %0d", process_id_out);
                fail_count++;
            end
            else
            begin
                want_res = pending_res_q[0];
                pending_res_q.delete(0);
                got_res = '{ok: result_valid, pid: process_id_out, prio: priority_out,
                            pre: preempt, drop: dropped};
                check_field("result_valid", want_res.ok, got_res.ok);
                check_field("process_id_out", want_res.pid, got_res.pid);
                check_field("priority_out", want_res.prio, got_res.prio);
                check_field("preempt", want_res.pre, got_res.pre);
                check_field("dropped", want_res.drop, got_res.drop);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("active_expired_priority_scheduler_core regression: fail");
            $finish;
        end
    end

    initial
    begin : stim
        sched_cmd_t cmd;
        int i;
        int j;
        int issued;
        int bursts;
        int burst_len;
        int add_pct;
        int get_pct;
        int exh_pct;
        bit no_idle;

        // cmd: func, pid, dyn, stat, cv, cp | given | res: ok, pid, prio, pre, drop
        stim_rows[0]  = '{'{aeps_pkg::FUNC_GET, 8'hA5, 5'sd0, 5'd0, 1'b0, 4'd0}, 1'b1,
                          '{1'b0, 8'hA5, 4'd0, 1'b0, 1'b0}};
        stim_rows[1]  = '{'{aeps_pkg::FUNC_NONE, 8'hFF, 5'sd15, 5'd31, 1'b1, 4'd15}, 1'b1,
                          '{1'b0, 8'hFF, 4'd0, 1'b0, 1'b0}};
        stim_rows[2]  = '{'{aeps_pkg::FUNC_PREEMPT, 8'h12, 5'sd15, 5'd16, 1'b1, 4'd0}, 1'b1,
                          '{1'b0, 8'h12, 4'd0, 1'b1, 1'b0}};
        // nothing running: never preempt
        stim_rows[3]  = '{'{aeps_pkg::FUNC_PREEMPT, 8'h13, 5'sd15, 5'd16, 1'b0, 4'd0}, 1'b1,
                          '{1'b0, 8'h13, 4'd0, 1'b0, 1'b0}};
        // exhausted incoming priority compares as negative
        stim_rows[4]  = '{'{aeps_pkg::FUNC_PREEMPT, 8'h14, -5'sd1, 5'd31, 1'b1, 4'd0}, 1'b1,
                          '{1'b0, 8'h14, 4'd0, 1'b0, 1'b0}};
        stim_rows[5]  = '{'{aeps_pkg::FUNC_PREEMPT, 8'h15, 5'sd5, 5'd1, 1'b1, 4'd5}, 1'b1,
                          '{1'b0, 8'h15, 4'd0, 1'b0, 1'b0}};
        stim_rows[6]  = '{'{aeps_pkg::FUNC_PREEMPT, 8'h16, -5'sd16, 5'd1, 1'b1, 4'd0}, 1'b1,
                          '{1'b0, 8'h16, 4'd0, 1'b0, 1'b0}};
        stim_rows[7]  = '{'{aeps_pkg::FUNC_ADD, 8'h00, 5'sd15, 5'd1, 1'b0, 4'd0}, 1'b1,
                          '{1'b1, 8'h00, 4'd15, 1'b0, 1'b0}};
        stim_rows[8]  = '{'{aeps_pkg::FUNC_ADD, 8'hFF, 5'sd0, 5'd31, 1'b1, 4'd15}, 1'b1,
                          '{1'b1, 8'hFF, 4'd0, 1'b0, 1'b0}};
        // below -1 clamps to zero
        stim_rows[9]  = '{'{aeps_pkg::FUNC_ADD, 8'h33, -5'sd16, 5'd16, 1'b0, 4'd0}, 1'b1,
                          '{1'b1, 8'h33, 4'd0, 1'b0, 1'b0}};
        // refill below zero clamps to zero
        stim_rows[10] = '{'{aeps_pkg::FUNC_ADD, 8'h44, -5'sd1, 5'd0, 1'b0, 4'd0}, 1'b1,
                          '{1'b1, 8'h44, 4'd0, 1'b0, 1'b0}};
        // refill above the top level clamps to the top
        stim_rows[11] = '{'{aeps_pkg::FUNC_ADD, 8'h55, -5'sd1, 5'd31, 1'b0, 4'd0}, 1'b1,
                          '{1'b1, 8'h55, 4'd15, 1'b0, 1'b0}};
        stim_rows[12] = '{'{aeps_pkg::FUNC_ADD, 8'h66, -5'sd1, 5'd16, 1'b1, 4'd0}, 1'b1,
                          '{1'b1, 8'h66, 4'd15, 1'b0, 1'b0}};
        stim_rows[13] = '{'{aeps_pkg::FUNC_ADD, 8'h77, -5'sd1, 5'd1, 1'b0, 4'd0}, 1'b1,
                          '{1'b1, 8'h77, 4'd0, 1'b0, 1'b0}};
        stim_rows[14] = '{'{aeps_pkg::FUNC_ADD, 8'h88, 5'sd7, 5'd1, 1'b0, 4'd0}, 1'b1,
                          '{1'b1, 8'h88, 4'd7, 1'b0, 1'b0}};
        stim_rows[15] = '{'{aeps_pkg::FUNC_GET, 8'h01, 5'sd0, 5'd0, 1'b0, 4'd0}, 1'b1,
                          '{1'b1, 8'h00, 4'd15, 1'b0, 1'b0}};
        stim_rows[16] = '{'{aeps_pkg::FUNC_GET, 8'h02, 5'sd0, 5'd0, 1'b0, 4'd0}, 1'b1,
                          '{1'b1, 8'h88, 4'd7, 1'b0, 1'b0}};
        stim_rows[17] = '{'{aeps_pkg::FUNC_GET, 8'h03, 5'sd0, 5'd0, 1'b0, 4'd0}, 1'b1,
                          '{1'b1, 8'hFF, 4'd0, 1'b0, 1'b0}};
        stim_rows[18] = '{'{aeps_pkg::FUNC_GET, 8'h04, 5'sd0, 5'd0, 1'b0, 4'd0}, 1'b1,
                          '{1'b1, 8'h33, 4'd0, 1'b0, 1'b0}};
        // active now empty: swap, then drain the former expired queue
        stim_rows[19] = '{'{aeps_pkg::FUNC_GET, 8'h05, 5'sd0, 5'd0, 1'b0, 4'd0}, 1'b0, '0};
        stim_rows[20] = '{'{aeps_pkg::FUNC_GET, 8'h06, 5'sd0, 5'd0, 1'b1, 4'd9}, 1'b0, '0};
        stim_rows[21] = '{'{aeps_pkg::FUNC_GET, 8'h07, 5'sd0, 5'd0, 1'b0, 4'd0}, 1'b0, '0};
        stim_rows[22] = '{'{aeps_pkg::FUNC_GET, 8'h08, 5'sd0, 5'd0, 1'b0, 4'd0}, 1'b0, '0};
        stim_rows[23] = '{'{aeps_pkg::FUNC_GET, 8'h09, 5'sd0, 5'd0, 1'b0, 4'd0}, 1'b1,
                          '{1'b0, 8'h09, 4'd0, 1'b0, 1'b0}};

        rst_n = 1'b0;
        start = 1'b0;
        func = aeps_pkg::FUNC_NONE;
        process_id = '0;
        dynamic_priority = '0;
        static_priority = '0;
        current_valid = 1'b0;
        current_priority = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIR_ROWS; i++)
        begin
            drive_beat(stim_rows[i].cmd, stim_rows[i].given, stim_rows[i].res);
            idle_gap(pick_gap(1'b0));
        end

        issued = DIR_ROWS;
        bursts = 0;
        while (issued < ITEM_COUNT)
        begin
            if (bursts < 2)
            begin
                // fill the active queue past full, then the expired one
                burst_len = 90;
                add_pct = 90;
                get_pct = 4;
                exh_pct = (bursts == 0) ? 0 : 100;
                no_idle = 1'b0;
            end
            else
            begin
                burst_len = $urandom_range(10, 60);
                no_idle = ($urandom_range(0, 3) == 0);
                case ($urandom_range(0, 3))
                    0: begin add_pct = 80; get_pct = 10; end
                    1: begin add_pct = 10; get_pct = 80; end
                    2: begin add_pct = 45; get_pct = 40; end
                    default: begin add_pct = 20; get_pct = 20; end
                endcase
                case ($urandom_range(0, 3))
                    0: exh_pct = 0;
                    1: exh_pct = 30;
                    2: exh_pct = 60;
                    default: exh_pct = 100;
                endcase
            end
            for (j = 0; j < burst_len && issued < ITEM_COUNT; j++)
            begin
                cmd = rand_cmd(add_pct, get_pct, exh_pct);
                drive_beat(cmd, 1'b0, '0);
                issued++;
                idle_gap(pick_gap(no_idle));
            end
            bursts++;
        end

        start <= 1'b0;
        while (pending_res_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("active_expired_priority_scheduler_core regression: pass");
        else
            $display("active_expired_priority_scheduler_core regression: fail");
        $finish;
    end

endmodule
